/* rtl/core/ps2kfr_pkg.sv */
// Shared constants, types and codes of the PS/2 keyboard frame receiver.
package ps2kfr_pkg;

    localparam int MAP_ENTRIES = 128;
    localparam int MAP_DEPTH   = 2 * MAP_ENTRIES;
    localparam int MAP_ADDR_W  = $clog2(MAP_DEPTH);

    localparam logic [8:0] MAP_ENTRIES_W9 = 9'(MAP_ENTRIES);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_LIMIT    = 2'd2;

    localparam logic [7:0] RST_RELEASE_CODE = 8'd240;
    localparam logic [7:0] RST_CTRL_CODE    = 8'd20;
    localparam logic [7:0] RST_MAP_LIMIT    = 8'd104;

    localparam logic REQ_SAMPLE    = 1'b0;
    localparam logic REQ_MAP_WRITE = 1'b1;

    localparam logic [7:0] STOP_ERR_CODE   = 8'd243;
    localparam logic [7:0] PARITY_ERR_CODE = 8'd244;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_STOP   = 2'd1;
    localparam logic [1:0] ST_PARITY = 2'd2;

    localparam logic [3:0] DATA_BITS  = 4'd8;
    localparam logic [3:0] FRAME_BITS = 4'd9;

    typedef struct packed {
        logic [7:0] release_code;
        logic [7:0] ctrl_code;
        logic [7:0] map_limit;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [7:0]            code;
        logic [1:0]            status;
        logic                  in_range;
        logic                  code_new;
        logic                  ctrl_after;
        logic [MAP_ADDR_W-1:0] addr;
    } t_stop;

endpackage

/* rtl/core/ps2kfr_if.sv */
// Handshake channel interfaces of the PS/2 keyboard frame receiver.
interface ps2kfr_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       data_bit;
    logic       map_select;
    logic [6:0] map_index;
    logic [7:0] map_value;

    modport source (output valid, req_type, data_bit, map_select, map_index, map_value,
                     input ready);
    modport sink   (input valid, req_type, data_bit, map_select, map_index, map_value,
                     output ready);
endinterface

interface ps2kfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;
    logic [7:0] ascii_char;
    logic       key_new;
    logic       ctrl_active;
    logic [1:0] frame_status;

    modport source (output valid, scan_code, ascii_char, key_new, ctrl_active, frame_status,
                     input ready);
    modport sink   (input valid, scan_code, ascii_char, key_new, ctrl_active, frame_status,
                     output ready);
endinterface

interface ps2kfr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ps2kfr_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ps2kfr_core_top.sv */
// Top level of the PS/2 keyboard frame receiver: config registers, character map and result stage.
// The block takes one item per clock cycle, sample or map write alike, unless stalled. A stop sample
// issues one synchronous read of the 256 x 8 character map memory; its result waits in the pending
// register beside that read, then moves into the output register. The input stalls only while a
// looked-up result cannot move into an occupied output register that is not being taken. The map
// memory is not cleared at reset: an entry must be written before a frame looks it up.
module ps2_keyboard_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ps2kfr_in_if.sink   i_in,
    ps2kfr_out_if.source o_out,
    ps2kfr_cfg_if.sink  i_cfg
);

    ps2kfr_pkg::t_cfg  r_cfg;
    ps2kfr_pkg::t_stop stop;

    logic       in_fire;
    logic       sample;
    logic       map_we;
    logic [ps2kfr_pkg::MAP_ADDR_W-1:0] map_waddr;
    logic [7:0] map_rdata;
    logic       advance;

    logic       r_pend_valid;
    logic [7:0] r_pend_code;
    logic [1:0] r_pend_status;
    logic       r_pend_in_range;
    logic       r_pend_code_new;
    logic       r_pend_ctrl;

    logic       r_out_valid;
    logic [7:0] r_out_code;
    logic [7:0] r_out_char;
    logic       r_out_key_new;
    logic       r_out_ctrl;
    logic [1:0] r_out_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_code <= ps2kfr_pkg::RST_RELEASE_CODE;
            r_cfg.ctrl_code    <= ps2kfr_pkg::RST_CTRL_CODE;
            r_cfg.map_limit    <= ps2kfr_pkg::RST_MAP_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ps2kfr_pkg::CFG_RELEASE_CODE: r_cfg.release_code <= i_cfg.data;
                ps2kfr_pkg::CFG_CTRL_CODE:    r_cfg.ctrl_code    <= i_cfg.data;
                ps2kfr_pkg::CFG_MAP_LIMIT:    r_cfg.map_limit    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_pend_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;
    assign sample     = in_fire && (i_in.req_type == ps2kfr_pkg::REQ_SAMPLE);
    assign map_we     = in_fire && (i_in.req_type == ps2kfr_pkg::REQ_MAP_WRITE)
                        && ({2'b00, i_in.map_index} < ps2kfr_pkg::MAP_ENTRIES_W9);
    assign map_waddr  = i_in.map_select
        ? ps2kfr_pkg::MAP_ADDR_W'(ps2kfr_pkg::MAP_ENTRIES)
          + ps2kfr_pkg::MAP_ADDR_W'(i_in.map_index)
        : ps2kfr_pkg::MAP_ADDR_W'(i_in.map_index);

    ps2kfr_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample),
        .i_bit    (i_in.data_bit),
        .i_cfg    (r_cfg),
        .o_stop   (stop)
    );

    ps2kfr_ram #(
        .WIDTH (8),
        .DEPTH (ps2kfr_pkg::MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (i_in.map_value),
        .i_re    (stop.valid),
        .i_raddr (stop.addr),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (stop.valid) begin
                r_pend_valid <= 1'b1;
            end else if (advance) begin
                r_pend_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_pend_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stop.valid) begin
            r_pend_code     <= stop.code;
            r_pend_status   <= stop.status;
            r_pend_in_range <= stop.in_range;
            r_pend_code_new <= stop.code_new;
            r_pend_ctrl     <= stop.ctrl_after;
        end
        if (advance && r_pend_valid) begin
            r_out_code    <= r_pend_code;
            r_out_char    <= r_pend_in_range ? map_rdata : 8'd0;
            r_out_key_new <= r_pend_in_range && r_pend_code_new && (map_rdata != 8'd0);
            r_out_ctrl    <= r_pend_ctrl;
            r_out_status  <= r_pend_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scan_code    = r_out_code;
    assign o_out.ascii_char   = r_out_char;
    assign o_out.key_new      = r_out_key_new;
    assign o_out.ctrl_active  = r_out_ctrl;
    assign o_out.frame_status = r_out_status;

endmodule

/* rtl/core/ps2kfr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ps2kfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ps2kfr_frame.sv */
// Frame assembly: start detection, bit gathering, parity, stop check and ctrl tracking.
module ps2kfr_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample,
    input  logic              i_bit,
    input  ps2kfr_pkg::t_cfg  i_cfg,
    output ps2kfr_pkg::t_stop o_stop
);

    logic       r_receiving, n_receiving;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_data_shift, n_data_shift;
    logic       r_parity, n_parity;
    logic [7:0] r_last_code, n_last_code;
    logic       r_ctrl, n_ctrl;

    logic       stop_now;
    logic [7:0] code;
    logic [1:0] status;
    logic       ctrl_after;

    always_comb begin
        stop_now = i_sample && r_receiving && (r_bit_count >= ps2kfr_pkg::FRAME_BITS);

        code   = r_data_shift;
        status = ps2kfr_pkg::ST_OK;
        if (!i_bit) begin
            code   = ps2kfr_pkg::STOP_ERR_CODE;
            status = ps2kfr_pkg::ST_STOP;
        end else if (!r_parity) begin
            code   = ps2kfr_pkg::PARITY_ERR_CODE;
            status = ps2kfr_pkg::ST_PARITY;
        end

        if (code == i_cfg.ctrl_code) begin
            ctrl_after = 1'b1;
        end else if (code == i_cfg.release_code) begin
            ctrl_after = 1'b0;
        end else begin
            ctrl_after = r_ctrl;
        end

        o_stop.valid      = stop_now;
        o_stop.code       = code;
        o_stop.status     = status;
        o_stop.in_range   = (code < i_cfg.map_limit) && ({1'b0, code} < ps2kfr_pkg::MAP_ENTRIES_W9);
        o_stop.code_new   = (code != r_last_code);
        o_stop.ctrl_after = ctrl_after;
        o_stop.addr       = r_ctrl
            ? ps2kfr_pkg::MAP_ADDR_W'(ps2kfr_pkg::MAP_ENTRIES) + ps2kfr_pkg::MAP_ADDR_W'(code)
            : ps2kfr_pkg::MAP_ADDR_W'(code);

        n_receiving  = r_receiving;
        n_bit_count  = r_bit_count;
        n_data_shift = r_data_shift;
        n_parity     = r_parity;
        n_last_code  = r_last_code;
        n_ctrl       = r_ctrl;

        if (i_sample) begin
            if (!r_receiving) begin
                if (!i_bit) begin
                    n_receiving = 1'b1;
                    n_bit_count = '0;
                    n_parity    = 1'b0;
                end
            end else if (!stop_now) begin
                if (r_bit_count < ps2kfr_pkg::DATA_BITS) begin
                    n_data_shift = {i_bit, r_data_shift[7:1]};
                end
                n_parity    = r_parity ^ i_bit;
                n_bit_count = r_bit_count + 4'd1;
            end else begin
                n_last_code = code;
                n_ctrl      = ctrl_after;
                n_receiving = 1'b0;
                n_bit_count = '0;
                n_parity    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_bit_count  <= '0;
            r_data_shift <= '0;
            r_parity     <= 1'b0;
            r_last_code  <= ps2kfr_pkg::RST_RELEASE_CODE;
            r_ctrl       <= 1'b0;
        end else begin
            r_receiving  <= n_receiving;
            r_bit_count  <= n_bit_count;
            r_data_shift <= n_data_shift;
            r_parity     <= n_parity;
            r_last_code  <= n_last_code;
            r_ctrl       <= n_ctrl;
        end
    end

endmodule
